### rtl/barometric_trend_forecaster_assert.svh
// Assertion macros shared by the checker of the barometric trend forecaster.
// Holds only macro definitions; no other file is needed to use them.
`ifndef BAROMETRIC_TREND_FORECASTER_ASSERT_SVH
`define BAROMETRIC_TREND_FORECASTER_ASSERT_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define BTF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define BTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btf_pkg.sv
// Package of the barometric trend forecaster: field widths, trend codes,
// the window-close bundle and the forecast letter tables. No dependencies.
package btf_pkg;

  localparam int PRESS_W  = 17;
  localparam int SUM_W    = 23;
  localparam int LETTER_W = 5;
  localparam int THR_W    = 10;
  localparam int DIFF_W   = PRESS_W + 1;

  localparam logic [THR_W-1:0] THR_RESET = 10'd30;

  typedef logic signed [1:0] trend_t;

  localparam trend_t TREND_STEADY = 2'sb00;
  localparam trend_t TREND_RISE   = 2'sb01;
  localparam trend_t TREND_FALL   = 2'sb11;

  // What the pipeline knows about an item when it reaches the judge stage.
  typedef struct packed {
    logic               closed;
    logic               ge2;
    logic [PRESS_W-1:0] mean;
    logic [PRESS_W-1:0] oldest;
  } btf_close_t;

  // Forecast letter from the trend and the current sample; thresholds are
  // hPa times 100 and the first row the sample reaches wins.
  function automatic logic [LETTER_W-1:0] zletter(trend_t tr, logic [PRESS_W-1:0] p);
    logic [LETTER_W-1:0] res;
    res = '0;
    if (tr == TREND_FALL) begin
      if      (p >= 17'd105000) res = 5'd1;
      else if (p >= 17'd104000) res = 5'd2;
      else if (p >= 17'd102400) res = 5'd4;
      else if (p >= 17'd101800) res = 5'd8;
      else if (p >= 17'd101000) res = 5'd15;
      else if (p >= 17'd100400) res = 5'd18;
      else if (p >= 17'd99800)  res = 5'd21;
      else if (p >= 17'd99100)  res = 5'd22;
      else if (p >= 17'd98500)  res = 5'd24;
    end else if (tr == TREND_RISE) begin
      if      (p >= 17'd103000) res = 5'd1;
      else if (p >= 17'd102200) res = 5'd2;
      else if (p >= 17'd101200) res = 5'd3;
      else if (p >= 17'd100700) res = 5'd6;
      else if (p >= 17'd100000) res = 5'd7;
      else if (p >= 17'd99500)  res = 5'd9;
      else if (p >= 17'd99000)  res = 5'd10;
      else if (p >= 17'd98400)  res = 5'd12;
      else if (p >= 17'd97800)  res = 5'd13;
      else if (p >= 17'd97000)  res = 5'd26;
      else if (p >= 17'd96500)  res = 5'd20;
      else if (p >= 17'd95900)  res = 5'd25;
      else if (p >= 17'd94700)  res = 5'd26;
    end else begin
      if      (p >= 17'd103300) res = 5'd1;
      else if (p >= 17'd102300) res = 5'd2;
      else if (p >= 17'd101400) res = 5'd5;
      else if (p >= 17'd100800) res = 5'd11;
      else if (p >= 17'd100000) res = 5'd14;
      else if (p >= 17'd99400)  res = 5'd16;
      else if (p >= 17'd98900)  res = 5'd19;
      else if (p >= 17'd98100)  res = 5'd23;
      else if (p >= 17'd97400)  res = 5'd24;
      else if (p >= 17'd96000)  res = 5'd26;
    end
    return res;
  endfunction

endpackage

### rtl/btf_hist_ram.sv
// Mean history memory: one write port and one read port with registered
// read data. Depends on nothing.
module btf_hist_ram #(
  parameter int DEPTH = 60,
  parameter int WIDTH = 17,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read, so a stalled reader keeps it.
  // A write to the entry being read in the same cycle is passed through.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

### rtl/btf_judge.sv
// Trend decision and forecast letter for the item in the last stage.
// Depends on btf_pkg for the trend codes, the close bundle and the letter tables.
module btf_judge
  import btf_pkg::*;
(
  input  btf_close_t          info,
  input  logic [THR_W-1:0]    threshold,
  input  trend_t              stored_trend,
  input  logic [PRESS_W-1:0]  pressure,
  output trend_t              trend,
  output logic [LETTER_W-1:0] letter
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] thr_pos;
  logic signed [DIFF_W-1:0] thr_neg;
  trend_t                   new_trend;

  always_comb begin
    diff    = $signed({1'b0, info.mean}) - $signed({1'b0, info.oldest});
    thr_pos = $signed({{(DIFF_W-THR_W){1'b0}}, threshold});
    thr_neg = -thr_pos;
    if (!info.ge2) begin
      new_trend = TREND_STEADY;
    end else if (diff > thr_pos) begin
      new_trend = TREND_RISE;
    end else if (diff < thr_neg) begin
      new_trend = TREND_FALL;
    end else begin
      new_trend = TREND_STEADY;
    end
    trend  = info.closed ? new_trend : stored_trend;
    letter = zletter(trend, pressure);
  end

endmodule

### rtl/barometric_trend_forecaster.sv
// Top level of the barometric trend forecaster: window averaging pipeline,
// history pointers and output register. Uses btf_pkg, btf_hist_ram and btf_judge.
//
// The block takes one pressure sample (0.01 hPa) per request and returns one
// result per request: a forecast letter 1..26 (0 when below every threshold),
// the stored trend, a flag for a sample that closed an averaging window, and
// the latest window mean. It sustains one request per clock cycle unless m_tready
// stalls the output; a result passes stages A to E and then the output register,
// and that register lets new requests enter while a result still waits. The
// one-per-cycle figure is set by the running sum register, which is updated in
// the accept cycle itself. The window mean is worked out without a divider: a
// multiply by the reciprocal of the window length, a multiply back by the
// length, and one correction step, each in a stage of its own. Window means
// live in a history memory with registered read data; the oldest mean is read
// when a window-closing sample leaves the first stage and the new mean is
// written when it reaches the output register. The history pointers advance at
// the read, so a later window close never reads an entry still in flight,
// except with two-sample windows: there the third close may read the first
// entry in the very cycle the first close writes it, and the memory passes the
// written mean straight to its read data. The history needs no clearing after
// reset. The threshold register is written through its own write channel,
// which is always ready; write it only while the block is idle.
module barometric_trend_forecaster
  import btf_pkg::*;
#(
  parameter int SAMPLES_PER_WINDOW = 60,
  parameter int HISTORY_DEPTH      = 60
) (
  input  logic             clk,
  input  logic             rst,
  // Request: bits 16:0 pressure, bits 23:17 zero.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [23:0]      s_tdata,
  // Result: bits 4:0 forecast_letter, 6:5 trend, 23:7 window_mean.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,
  // Result flag: bit 0 window_closed.
  output logic [0:0]       m_tuser,
  // Threshold register write channel.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(SAMPLES_PER_WINDOW + 1);
  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int PROD_W = 2 * SUM_W;
  localparam int QN_W   = SUM_W + CNT_W;

  // Reciprocal of the window length scaled by 2^SUM_W; the estimate it gives
  // is at most one below the true quotient for any sum below 2^SUM_W.
  localparam logic [SUM_W-1:0]  RECIP     = SUM_W'((64'd1 << SUM_W) / SAMPLES_PER_WINDOW);
  localparam logic [CNT_W-1:0]  N_CNT     = CNT_W'(SAMPLES_PER_WINDOW);
  localparam logic [SUM_W-1:0]  N_SUM     = SUM_W'(SAMPLES_PER_WINDOW);
  localparam logic [QN_W-1:0]   N_QN      = QN_W'(SAMPLES_PER_WINDOW);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
  localparam logic [FILL_W-1:0] FILL_TWO  = FILL_W'(2);

  // Configuration and window state.
  logic [THR_W-1:0]   threshold;
  logic [SUM_W-1:0]   running_sum;
  logic [CNT_W-1:0]   sample_count;
  logic [FILL_W-1:0]  history_fill;
  logic [AW-1:0]      history_write_index;
  trend_t             stored_trend;
  logic [PRESS_W-1:0] last_mean;

  // Pipeline stages A..E, then the output register.
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic a_free, b_free, c_free, d_free, e_free, out_free;

  logic [PRESS_W-1:0] a_p, b_p, c_p, d_p, e_p;
  logic               a_closed, b_closed, c_closed, d_closed, e_closed;
  logic [SUM_W-1:0]   a_sum, b_sum, c_sum, d_sum;
  logic [PROD_W-1:0]  b_prod;
  logic [SUM_W-1:0]   c_qest, d_qest;
  logic [QN_W-1:0]    d_qn;
  logic [AW-1:0]      b_waddr, c_waddr, d_waddr, e_waddr;
  logic               b_ge2, c_ge2, d_ge2, e_ge2;
  logic [PRESS_W-1:0] c_old, d_old, e_old;
  logic [PRESS_W-1:0] e_mean;

  logic               accept;
  logic [PRESS_W-1:0] pressure;
  logic               rd_issue;
  logic [AW-1:0]      rd_addr;
  logic [PRESS_W-1:0] rd_data;
  logic               wr_en;
  logic [SUM_W-1:0]   d_rem;
  logic [SUM_W-1:0]   d_mean_full;
  btf_close_t         e_info;
  trend_t             j_trend;
  logic [LETTER_W-1:0] j_letter;

  // Each stage takes a new item when it is empty or its item moves on.
  assign out_free = !m_tvalid || m_tready;
  assign e_free   = !e_valid  || out_free;
  assign d_free   = !d_valid  || e_free;
  assign c_free   = !c_valid  || d_free;
  assign b_free   = !b_valid  || c_free;
  assign a_free   = !a_valid  || b_free;

  assign s_tready  = a_free;
  assign accept    = s_tvalid && s_tready;
  assign pressure  = s_tdata[PRESS_W-1:0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  // Running sum: a sample either adds in, or closes the window and starts
  // the next sum. The old sum travels down the pipeline with the closing sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (sample_count < N_CNT) begin
        running_sum  <= SUM_W'(running_sum + {{(SUM_W-PRESS_W){1'b0}}, pressure});
        sample_count <= CNT_W'(sample_count + 1'b1);
      end else begin
        running_sum  <= {{(SUM_W-PRESS_W){1'b0}}, pressure};
        sample_count <= CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free) begin
      a_p      <= pressure;
      a_closed <= !(sample_count < N_CNT);
      a_sum    <= running_sum;
    end
  end

  // History pointers move when the oldest mean is read. Until the history is
  // full the oldest entry is the first one; after that it is the entry about
  // to be overwritten.
  assign rd_issue = b_free && a_valid && a_closed;
  assign rd_addr  = (history_fill < FILL_FULL) ? '0 : history_write_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_fill        <= '0;
      history_write_index <= '0;
    end else if (rd_issue) begin
      history_write_index <= (history_write_index == LAST_ADDR) ? '0
                             : AW'(history_write_index + 1'b1);
      if (history_fill < FILL_FULL) begin
        history_fill <= FILL_W'(history_fill + 1'b1);
      end
    end
  end

  // Stage B: reciprocal product.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_p      <= a_p;
      b_closed <= a_closed;
      b_sum    <= a_sum;
      b_prod   <= {{SUM_W{1'b0}}, a_sum} * {{SUM_W{1'b0}}, RECIP};
      b_waddr  <= history_write_index;
      b_ge2    <= (history_fill >= FILL_TWO);
    end
  end

  // Stage C: quotient estimate and the oldest mean from memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_free) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free) begin
      c_p      <= b_p;
      c_closed <= b_closed;
      c_sum    <= b_sum;
      c_qest   <= b_prod[PROD_W-1:SUM_W];
      c_waddr  <= b_waddr;
      c_ge2    <= b_ge2;
      c_old    <= rd_data;
    end
  end

  // Stage D: estimate times window length.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_free) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_free) begin
      d_p      <= c_p;
      d_closed <= c_closed;
      d_sum    <= c_sum;
      d_qest   <= c_qest;
      d_qn     <= {{CNT_W{1'b0}}, c_qest} * N_QN;
      d_waddr  <= c_waddr;
      d_ge2    <= c_ge2;
      d_old    <= c_old;
    end
  end

  // The remainder of the estimate is below twice the window length, so one
  // compare and increment gives the floor of the mean.
  assign d_rem       = d_sum - d_qn[SUM_W-1:0];
  assign d_mean_full = SUM_W'(d_qest + {{(SUM_W-1){1'b0}}, (d_rem >= N_SUM)});

  // Stage E: finished mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (e_free) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_free) begin
      e_p      <= d_p;
      e_closed <= d_closed;
      e_mean   <= d_mean_full[PRESS_W-1:0];
      e_waddr  <= d_waddr;
      e_ge2    <= d_ge2;
      e_old    <= d_old;
    end
  end

  assign e_info = '{closed: e_closed, ge2: e_ge2, mean: e_mean, oldest: e_old};

  btf_judge u_judge (
    .info         (e_info),
    .threshold    (threshold),
    .stored_trend (stored_trend),
    .pressure     (e_p),
    .trend        (j_trend),
    .letter       (j_letter)
  );

  // A closing sample commits its trend, mean and history entry as it moves
  // into the output register.
  assign wr_en = e_valid && out_free && e_closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_trend <= TREND_STEADY;
      last_mean    <= '0;
    end else if (wr_en) begin
      stored_trend <= j_trend;
      last_mean    <= e_mean;
    end
  end

  btf_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (PRESS_W),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (wr_en),
    .waddr (e_waddr),
    .wdata (e_mean),
    .re    (rd_issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= {(e_closed ? e_mean : last_mean), j_trend, j_letter};
      m_tuser <= e_closed;
    end
  end

endmodule

### rtl/btf_checker.sv
// Port-level checker for the barometric trend forecaster and its bind.
// Depends on btf_pkg and on the assertion macros header.
`include "barometric_trend_forecaster_assert.svh"

module btf_checker
  import btf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic               out_acc;
  logic [1:0]         prev_trend;
  logic [PRESS_W-1:0] prev_mean;

  assign out_acc = m_tvalid && m_tready;

  // Trend and mean of the last delivered result; both start steady and zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_trend <= '0;
      prev_mean  <= '0;
    end else if (out_acc) begin
      prev_trend <= m_tdata[6:5];
      prev_mean  <= m_tdata[23:7];
    end
  end

  `BTF_ASSERT_SAME(a_letter_range, clk, rst, m_tvalid, m_tdata[4:0] <= 5'd26, "forecast letter out of range")
  `BTF_ASSERT_SAME(a_trend_held, clk, rst, out_acc && !m_tuser[0], m_tdata[6:5] == prev_trend, "trend changed without a window close")
  `BTF_ASSERT_SAME(a_mean_held, clk, rst, out_acc && !m_tuser[0], m_tdata[23:7] == prev_mean, "window mean changed without a window close")
  `BTF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind barometric_trend_forecaster btf_checker u_btf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
